@@ rtl/core/e2dcm_pkg.sv @@
// Package: shared constants and CORDIC arctangent table for the Euler-to-DCM block.
`default_nettype none
package e2dcm_pkg;
    localparam int TABLE_LEN   = 24;
    localparam int CORDIC_FRAC = 30;
    localparam int FULL_TURN   = 23040;
    localparam int QUARTER     = 5760;
    localparam longint CORDIC_GAIN = 64'sd652032874;
    localparam int ZW = 34;
    localparam int XW = 33;

    function automatic logic signed [ZW-1:0] atan_at(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0: v = 34'sd536870912;
            1: v = 34'sd316933406;
            2: v = 34'sd167458907;
            3: v = 34'sd85004756;
            4: v = 34'sd42667331;
            5: v = 34'sd21354465;
            6: v = 34'sd10679838;
            7: v = 34'sd5340245;
            8: v = 34'sd2670163;
            9: v = 34'sd1335087;
            10: v = 34'sd667544;
            11: v = 34'sd333772;
            12: v = 34'sd166886;
            13: v = 34'sd83443;
            14: v = 34'sd41722;
            15: v = 34'sd20861;
            16: v = 34'sd10430;
            17: v = 34'sd5215;
            18: v = 34'sd2608;
            19: v = 34'sd1304;
            20: v = 34'sd652;
            21: v = 34'sd326;
            22: v = 34'sd163;
            23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/e2dcm_cossin.sv @@
// Angle reduction and pipelined CORDIC giving one cosine/sine pair.
`default_nettype none
module e2dcm_cossin import e2dcm_pkg::*; #(
    parameter int ANGLE_WIDTH    = 16,
    parameter int COEF_FRAC_BITS = 14,
    parameter int CORDIC_STAGES  = 16
) (
    input  wire                              i_clk,
    input  wire                              i_en,
    input  wire signed [ANGLE_WIDTH-1:0]     i_angle,
    output logic signed [COEF_FRAC_BITS+1:0] o_cos,
    output logic signed [COEF_FRAC_BITS+1:0] o_sin
);
    localparam int NS = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int SH = CORDIC_FRAC - COEF_FRAC_BITS;
    localparam int HW = ANGLE_WIDTH - 3;

    // stage A: angle as 512-unit block index (biased positive) and offset in block
    logic [HW-1:0] r_hu;
    logic [8:0]    r_lo;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hu <= HW'(i_angle >>> 9) + HW'(45 * (1 << (ANGLE_WIDTH - 10)));
            r_lo <= i_angle[8:0];
        end
    end

    // stage A2: block index modulo 45 by reciprocal multiply and one correction
    logic [HW+15:0] n_hp;
    logic [HW-1:0]  n_hq;
    logic [HW-1:0]  n_hr;
    always_comb begin
        n_hp = (HW+16)'(r_hu) * (HW+16)'(46603);
        n_hq = HW'(n_hp >> 21);
        n_hr = r_hu - HW'(n_hq * HW'(45));
        if (n_hr >= HW'(45)) n_hr = n_hr - HW'(45);
    end
    logic [14:0] r_m;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m <= {n_hr[5:0], r_lo};
        end
    end

    // stage B: quadrant and binary angle
    logic [1:0]            r_q0;
    logic signed [ZW-1:0]  r_z0;
    logic [12:0]           n_r;
    logic [1:0]            n_q;
    always_comb begin
        if (r_m >= 15'(3*QUARTER)) begin
            n_q = 2'd3; n_r = 13'(r_m - 15'(3*QUARTER));
        end else if (r_m >= 15'(2*QUARTER)) begin
            n_q = 2'd2; n_r = 13'(r_m - 15'(2*QUARTER));
        end else if (r_m >= 15'(QUARTER)) begin
            n_q = 2'd1; n_r = 13'(r_m - 15'(QUARTER));
        end else begin
            n_q = 2'd0; n_r = r_m[12:0];
        end
    end
    logic [36:0] r_zn;
    logic [1:0]  r_qa;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zn <= {1'b0, n_r, 23'd0} + 37'd22;
            r_qa <= n_q;
        end
    end
    // divide by 45 via reciprocal multiply and correction
    logic [36:0] n_qt;
    logic [36:0] n_rem;
    logic [74:0] n_prod;
    always_comb begin
        n_prod = 75'(r_zn) * 75'd3054198966;
        n_qt   = 37'(n_prod >> 37);
        n_rem  = r_zn - 37'(n_qt * 37'd45);
        if (n_rem >= 37'd45) n_qt = n_qt + 37'd1;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z0 <= ZW'(signed'({1'b0, n_qt}));
            r_q0 <= r_qa;
        end
    end

    logic signed [XW-1:0] r_x [NS];
    logic signed [XW-1:0] r_y [NS];
    logic signed [ZW-1:0] r_z [NS];
    logic [1:0]           r_q [NS];
    for (genvar g = 0; g < NS; g++) begin : g_st
        logic signed [XW-1:0] x_in;
        logic signed [XW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic [1:0]           q_in;
        if (g == 0) begin : g_head
            assign x_in = XW'(CORDIC_GAIN);
            assign y_in = '0;
            assign z_in = r_z0;
            assign q_in = r_q0;
        end else begin : g_tail
            assign x_in = r_x[g-1];
            assign y_in = r_y[g-1];
            assign z_in = r_z[g-1];
            assign q_in = r_q[g-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!z_in[ZW-1]) begin
                    r_x[g] <= x_in - (y_in >>> g);
                    r_y[g] <= y_in + (x_in >>> g);
                    r_z[g] <= z_in - atan_at(g);
                end else begin
                    r_x[g] <= x_in + (y_in >>> g);
                    r_y[g] <= y_in - (x_in >>> g);
                    r_z[g] <= z_in + atan_at(g);
                end
                r_q[g] <= q_in;
            end
        end
    end

    logic signed [XW-1:0] n_c, n_s;
    always_comb begin
        case (r_q[NS-1])
            2'd1: begin n_c = -r_y[NS-1]; n_s = r_x[NS-1]; end
            2'd2: begin n_c = -r_x[NS-1]; n_s = -r_y[NS-1]; end
            2'd3: begin n_c = r_y[NS-1]; n_s = -r_x[NS-1]; end
            default: begin n_c = r_x[NS-1]; n_s = r_y[NS-1]; end
        endcase
    end

    function automatic logic signed [CW-1:0] to_coef(input logic signed [XW-1:0] v);
        logic signed [XW:0] t;
        logic signed [XW:0] lim;
        t = (XW+1)'(v) + (XW+1)'(1 <<< (SH-1));
        t = t >>> SH;
        lim = (XW+1)'(1) <<< COEF_FRAC_BITS;
        if (t > lim) t = lim;
        if (t < -lim) t = -lim;
        return CW'(t);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= to_coef(n_c);
            o_sin <= to_coef(n_s);
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/e2dcm_matrix.sv @@
// Three-stage product and sum pipeline forming the nine DCM entries.
`default_nettype none
module e2dcm_matrix import e2dcm_pkg::*; #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire                              i_clk,
    input  wire                              i_en,
    input  wire signed [COEF_FRAC_BITS+1:0]  i_cx,
    input  wire signed [COEF_FRAC_BITS+1:0]  i_sx,
    input  wire signed [COEF_FRAC_BITS+1:0]  i_cy,
    input  wire signed [COEF_FRAC_BITS+1:0]  i_sy,
    input  wire signed [COEF_FRAC_BITS+1:0]  i_cz,
    input  wire signed [COEF_FRAC_BITS+1:0]  i_sz,
    output logic signed [COEF_FRAC_BITS+1:0] o_e [9]
);
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int PW = 2 * CW;

    function automatic logic signed [CW-1:0] sat(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] lim;
        lim = PW'(1) <<< COEF_FRAC_BITS;
        if (v > lim) return CW'(lim);
        if (v < -lim) return CW'(-lim);
        return CW'(v);
    endfunction

    function automatic logic signed [CW-1:0] mulr(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b) + (PW'(1) <<< (COEF_FRAC_BITS - 1));
        return sat(p >>> COEF_FRAC_BITS);
    endfunction

    // stage 1: pair products
    logic signed [CW-1:0] r_cycz, r_cysz, r_nsy, r_szcx, r_sxcz, r_czcx, r_sxsz;
    logic signed [CW-1:0] r_sxcy, r_cycx, r_sy1;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cycz <= mulr(i_cy, i_cz);
            r_cysz <= mulr(i_cy, i_sz);
            r_nsy  <= sat(-PW'(i_sy));
            r_szcx <= mulr(i_sz, i_cx);
            r_sxcz <= mulr(i_sx, i_cz);
            r_czcx <= mulr(i_cz, i_cx);
            r_sxsz <= mulr(i_sx, i_sz);
            r_sxcy <= mulr(i_sx, i_cy);
            r_cycx <= mulr(i_cy, i_cx);
            r_sy1  <= i_sy;
        end
    end

    // stage 2: triple products
    logic signed [CW-1:0] r_p [9];
    logic signed [CW-1:0] r_t3, r_t4, r_t6, r_t7;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= r_cycz;
            r_p[1] <= r_cysz;
            r_p[2] <= r_nsy;
            r_p[3] <= r_szcx;
            r_p[4] <= r_czcx;
            r_p[5] <= r_sxcy;
            r_p[6] <= r_sxsz;
            r_p[7] <= r_sxcz;
            r_p[8] <= r_cycx;
            r_t3 <= mulr(r_sxcz, r_sy1);
            r_t4 <= mulr(r_sxsz, r_sy1);
            r_t6 <= mulr(r_czcx, r_sy1);
            r_t7 <= mulr(r_szcx, r_sy1);
        end
    end

    // stage 3: sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_e[0] <= r_p[0];
            o_e[1] <= r_p[1];
            o_e[2] <= r_p[2];
            o_e[3] <= sat(PW'(r_t3) - PW'(r_p[3]));
            o_e[4] <= sat(PW'(r_p[4]) + PW'(r_t4));
            o_e[5] <= r_p[5];
            o_e[6] <= sat(PW'(r_p[6]) + PW'(r_t6));
            o_e[7] <= sat(PW'(r_t7) - PW'(r_p[7]));
            o_e[8] <= r_p[8];
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/euler_to_direction_cosine_matrix.sv @@
// Top level: Euler angles (roll, pitch, yaw) to direction cosine matrix.
// The CORDIC uses CORDIC_STAGES iterations, capped at 24, between angle reduction and the matrix pipeline.
// Throughput: one item per cycle; a stall at the output freezes the whole pipeline.
// Reset clears only the stage valid bits; data registers are not reset.
`default_nettype none
module euler_to_direction_cosine_matrix import e2dcm_pkg::*; #(
    parameter int ANGLE_WIDTH    = 16,
    parameter int COEF_FRAC_BITS = 14,
    parameter int CORDIC_STAGES  = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire signed [ANGLE_WIDTH-1:0]     i_roll_angle,
    input  wire signed [ANGLE_WIDTH-1:0]     i_pitch_angle,
    input  wire signed [ANGLE_WIDTH-1:0]     i_yaw_angle,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic signed [COEF_FRAC_BITS+1:0] o_dcm_r0c0,
    output logic signed [COEF_FRAC_BITS+1:0] o_dcm_r0c1,
    output logic signed [COEF_FRAC_BITS+1:0] o_dcm_r0c2,
    output logic signed [COEF_FRAC_BITS+1:0] o_dcm_r1c0,
    output logic signed [COEF_FRAC_BITS+1:0] o_dcm_r1c1,
    output logic signed [COEF_FRAC_BITS+1:0] o_dcm_r1c2,
    output logic signed [COEF_FRAC_BITS+1:0] o_dcm_r2c0,
    output logic signed [COEF_FRAC_BITS+1:0] o_dcm_r2c1,
    output logic signed [COEF_FRAC_BITS+1:0] o_dcm_r2c2
);
    localparam int NS  = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int LAT = NS + 8;
    localparam int CW  = COEF_FRAC_BITS + 2;

    logic en;
    logic [LAT-1:0] r_vld;
    assign o_valid = r_vld[LAT-1];
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    logic signed [CW-1:0] cx, sx, cy, sy, cz, sz;
    logic signed [CW-1:0] e [9];

    e2dcm_cossin #(.ANGLE_WIDTH(ANGLE_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS),
        .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
        .i_clk(i_clk), .i_en(en), .i_angle(i_roll_angle), .o_cos(cx), .o_sin(sx));
    e2dcm_cossin #(.ANGLE_WIDTH(ANGLE_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS),
        .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk(i_clk), .i_en(en), .i_angle(i_pitch_angle), .o_cos(cy), .o_sin(sy));
    e2dcm_cossin #(.ANGLE_WIDTH(ANGLE_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS),
        .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk(i_clk), .i_en(en), .i_angle(i_yaw_angle), .o_cos(cz), .o_sin(sz));

    e2dcm_matrix #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mat (
        .i_clk(i_clk), .i_en(en),
        .i_cx(cx), .i_sx(sx), .i_cy(cy), .i_sy(sy), .i_cz(cz), .i_sz(sz),
        .o_e(e));

    assign o_dcm_r0c0 = e[0];
    assign o_dcm_r0c1 = e[1];
    assign o_dcm_r0c2 = e[2];
    assign o_dcm_r1c0 = e[3];
    assign o_dcm_r1c1 = e[4];
    assign o_dcm_r1c2 = e[5];
    assign o_dcm_r2c0 = e[6];
    assign o_dcm_r2c1 = e[7];
    assign o_dcm_r2c2 = e[8];
endmodule
`default_nettype wire
